// ----- rtl/gsgm_pkg.sv -----
// gsgm_pkg: shared types and constants of the gf2 series generating matrix core
// depends on nothing; used by every rtl module of the block
`timescale 1ns / 1ps
`default_nettype none

package gsgm_pkg;

  // fixed field widths
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned DEG_W          = 7;
  localparam int unsigned IDX_W          = 6;
  localparam int unsigned ADDR_W         = 4;
  localparam int unsigned MAX_DEGREE_DEF = 64;

  // register reset values
  localparam logic [DATA_W-1:0] COEFFS_RST = '0;
  localparam logic [DEG_W-1:0]  DEGREE_RST = 7'd32;

  // register indexes, decoded from the 8-byte word address
  typedef enum logic {
    REG_COEFFS = 1'b0,
    REG_DEGREE = 1'b1
  } gsgm_reg_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_EMIT
  } gsgm_state_e;

  // common control for the cell row
  typedef struct packed {
    logic clear;
    logic shift;
  } gsgm_cell_ctrl_t;

  // sequencer outputs to the datapath
  typedef struct packed {
    gsgm_cell_ctrl_t row;
    logic            load;
    logic            out_valid;
    logic            last;
  } gsgm_seq_t;

endpackage

`default_nettype wire

// ----- rtl/gsgm_cell.sv -----
// gsgm_cell: one row of the series window, a single bit handed to its lower neighbor
// depends on gsgm_pkg
`timescale 1ns / 1ps
`default_nettype none

module gsgm_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  gsgm_pkg::gsgm_cell_ctrl_t ctrl_i,
  input  logic                     active_i,
  input  logic                     tail_i,
  input  logic                     nbr_i,
  input  logic                     fb_i,
  input  logic                     coef_i,
  output logic                     bit_o,
  output logic                     tap_o
);
  import gsgm_pkg::*;

  logic bit_d, bit_q;

  // rows beyond the degree stay zero, the tail row takes the new series bit
  always_comb begin
    bit_d = bit_q;
    if (ctrl_i.clear) begin
      bit_d = 1'b0;
    end else if (ctrl_i.shift) begin
      bit_d = active_i ? (tail_i ? fb_i : nbr_i) : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  // contribution of this row to the feedback parity
  assign bit_o = bit_q;
  assign tap_o = bit_q & coef_i;

endmodule

`default_nettype wire

// ----- rtl/gsgm_ctrl.sv -----
// gsgm_ctrl: sequencer for window fill and column emission
// depends on gsgm_pkg
`timescale 1ns / 1ps
`default_nettype none

module gsgm_ctrl #(
  parameter int unsigned MAX_DEGREE = gsgm_pkg::MAX_DEGREE_DEF,
  localparam int unsigned IW        = $clog2(MAX_DEGREE)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  input  logic               m_zero_i,
  input  logic [IW-1:0]      m_last_i,
  output gsgm_pkg::gsgm_seq_t seq_o,
  output logic [IW-1:0]      cnt_o
);
  import gsgm_pkg::*;

  gsgm_state_e state_d, state_q;
  logic [IW-1:0] cnt_d, cnt_q;
  logic          at_last;

  assign at_last = (cnt_q == m_last_i);

  // next state and counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i && !m_zero_i) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        if (at_last) begin
          state_d = ST_EMIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (at_last) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    seq_o           = '0;
    seq_o.last      = at_last;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        seq_o.load      = in_valid_i;
        seq_o.row.clear = in_valid_i;
      end
      ST_FILL: begin
        seq_o.row.shift = 1'b1;
      end
      ST_EMIT: begin
        seq_o.out_valid = 1'b1;
        seq_o.row.shift = out_ready_i && !at_last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

`default_nettype wire

// ----- rtl/gf2_series_generating_matrix_core.sv -----
// gf2_series_generating_matrix_core: top level, config registers, q stream and cell row
// depends on gsgm_pkg, gsgm_cell, gsgm_ctrl
// output: after the input transfer the window fills, then one column per cycle while out_ready_i is high
// input: a new polynomial is accepted only in ST_IDLE, once the last column of the previous one
//   has been taken; the cell row produces one series bit per cycle while it shifts
// reset: sequencer idle, window cleared, modulus coefficients 0, degree 32
`timescale 1ns / 1ps
`default_nettype none

module gf2_series_generating_matrix_core #(
  parameter int unsigned MAX_DEGREE = gsgm_pkg::MAX_DEGREE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gsgm_pkg::ADDR_W-1:0]  paddr,
  input  logic [gsgm_pkg::DATA_W-1:0]  pwdata,
  output logic [gsgm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gsgm_pkg::DATA_W-1:0]  gen_poly_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gsgm_pkg::IDX_W-1:0]   column_index_o,
  output logic [gsgm_pkg::DATA_W-1:0]  column_bits_o,
  output logic                         last_column_o
);
  import gsgm_pkg::*;

  localparam int unsigned IW = $clog2(MAX_DEGREE);

  logic [DATA_W-1:0] coeffs_q;
  logic [DEG_W-1:0]  degree_q;
  logic              cfg_wr;
  gsgm_reg_e         reg_sel;

  // config write transfer and readback
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = gsgm_reg_e'(paddr[ADDR_W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeffs_q <= COEFFS_RST;
      degree_q <= DEGREE_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_COEFFS: coeffs_q <= pwdata;
        REG_DEGREE: degree_q <= pwdata[DEG_W-1:0];
        default:    coeffs_q <= coeffs_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_COEFFS: prdata = coeffs_q;
      REG_DEGREE: prdata = DATA_W'(degree_q);
      default:    prdata = '0;
    endcase
  end

  // effective degree, saturated to the row length
  logic          m_zero;
  logic [IW-1:0] m_last;

  assign m_zero = (degree_q == '0);
  assign m_last = (degree_q > DEG_W'(MAX_DEGREE)) ? IW'(MAX_DEGREE - 1)
                                                   : IW'(degree_q - 1'b1);

  // sequencer
  gsgm_seq_t     seq;
  logic [IW-1:0] cnt;

  gsgm_ctrl #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .m_zero_i    (m_zero),
    .m_last_i    (m_last),
    .seq_o       (seq),
    .cnt_o       (cnt)
  );

  // generating polynomial, streamed from coefficient m-1 downward
  logic [MAX_DEGREE-1:0] q_d, q_q;
  logic                  q_bit;

  always_comb begin
    q_d = q_q;
    if (seq.load) begin
      q_d = gen_poly_i[MAX_DEGREE-1:0];
    end else if (seq.row.shift) begin
      q_d = {q_q[MAX_DEGREE-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_bit = q_q[m_last];

  // cell row: row r holds series bit c+r+1 while column c is shown
  logic [MAX_DEGREE-1:0] win;
  logic [MAX_DEGREE-1:0] taps;
  logic                  fb;

  assign fb = q_bit ^ (^taps);

  for (genvar r = 0; r < MAX_DEGREE; r++) begin : g_cell
    logic nbr;
    if (r == MAX_DEGREE - 1) begin : g_end
      assign nbr = 1'b0;
    end else begin : g_mid
      assign nbr = win[r+1];
    end

    gsgm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (seq.row),
      .active_i (IW'(r) <= m_last),
      .tail_i   (IW'(r) == m_last),
      .nbr_i    (nbr),
      .fb_i     (fb),
      .coef_i   (coeffs_q[r]),
      .bit_o    (win[r]),
      .tap_o    (taps[r])
    );
  end

  // result
  assign out_valid_o    = seq.out_valid;
  assign column_index_o = IDX_W'(cnt);
  assign column_bits_o  = DATA_W'(win);
  assign last_column_o  = seq.last;

endmodule

`default_nettype wire

// ----- tb/sv/tb_gf2_series_generating_matrix_core.sv -----
// tb_gf2_series_generating_matrix_core: self-checking bench for the gf2 series matrix core
// depends on gsgm_pkg and gf2_series_generating_matrix_core; predicts every column itself
// covers directed corner polynomials, then random config phases with random stalls
`timescale 1ns / 1ps

module tb_gf2_series_generating_matrix_core;
  import gsgm_pkg::*;

  localparam int unsigned MAX_DEG      = 64;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned RANDOM_ITEMS = 270;

  typedef struct packed {
    logic [IDX_W-1:0]  col_idx;
    logic [DATA_W-1:0] col_bits;
    logic              col_last;
  } column_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [DATA_W-1:0] gen_poly_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [IDX_W-1:0]  column_index_o;
  logic [DATA_W-1:0] column_bits_o;
  logic              last_column_o;

  // bench copy of the config registers
  logic [DATA_W-1:0] cfg_coeffs = COEFFS_RST;
  logic [DEG_W-1:0]  cfg_degree = DEGREE_RST;

  logic [DATA_W-1:0] pending_polys[$];
  column_t           expected_columns[$];
  int unsigned       mismatch_count = 0;
  int unsigned       idle_pct       = 0;
  logic              hold_req       = 1'b0;
  logic              hold_done      = 1'b0;
  int unsigned       hold_left      = 0;
  int unsigned       in_gap         = 0;
  int unsigned       out_gap        = 0;
  int unsigned       quiet_cycles   = 0;

  gf2_series_generating_matrix_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .gen_poly_i     (gen_poly_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .column_index_o (column_index_o),
    .column_bits_o  (column_bits_o),
    .last_column_o  (last_column_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // degree after saturation
  function automatic int unsigned eff_degree(input logic [DEG_W-1:0] deg);
    return (deg > MAX_DEG) ? MAX_DEG : int'(deg);
  endfunction

  // append one polynomial to the pending queue
  function automatic void add_poly(input logic [DATA_W-1:0] poly);
    pending_polys = {pending_polys, poly};
  endfunction

  // expand the series of q over the modulus and queue the hankel columns
  function automatic void predict_columns(input logic [DATA_W-1:0] q);
    logic [2*MAX_DEG-1:0] series;
    int unsigned          m, l, p, first, r, c;
    logic                 bit_v;
    column_t              col;
    m = eff_degree(cfg_degree);
    if (m == 0) return;
    series = '0;
    for (l = 1; l <= 2 * m; l++) begin
      bit_v = (l <= m) ? q[m-l] : 1'b0;
      first = (l > m + 1) ? l - m : 1;
      for (p = first; p < l; p++) bit_v ^= series[p-1] & cfg_coeffs[m-l+p];
      series[l-1] = bit_v;
    end
    for (c = 0; c < m; c++) begin
      col.col_idx  = c[IDX_W-1:0];
      col.col_bits = '0;
      for (r = 0; r < m; r++) col.col_bits[r] = series[c+r];
      col.col_last = (c == m - 1);
      expected_columns = {expected_columns, col};
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // input driver: sends pending polynomials with random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gen_poly_i <= '0;
      in_gap     <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        in_valid_i <= 1'b0;
        in_gap     <= $urandom_range(9, 0);
      end else if (pending_polys.size() != 0) begin
        in_valid_i <= 1'b1;
        gen_poly_i <= pending_polys.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output ready: one long hold-off on request, otherwise random stall bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES - 1;
      hold_done   <= 1'b1;
    end else if (out_gap != 0) begin
      out_ready_i <= 1'b0;
      out_gap     <= out_gap - 1;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      out_ready_i <= 1'b0;
      out_gap     <= $urandom_range(9, 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor: predict on input transfer, check on output transfer, watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    column_t want;
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_columns(gen_poly_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_columns.size() == 0) begin
          note_mismatch($sformatf("unexpected column idx %0d bits %h last %b",
                                  column_index_o, column_bits_o, last_column_o));
        end else begin
          want = expected_columns.pop_front();
          if (column_index_o !== want.col_idx || column_bits_o !== want.col_bits ||
              last_column_o !== want.col_last)
            note_mismatch($sformatf(
              "expected idx %0d bits %h last %b, got idx %0d bits %h last %b",
              want.col_idx, want.col_bits, want.col_last,
              column_index_o, column_bits_o, last_column_o));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // apb write: setup cycle, then access cycle until pready
  task automatic reg_write(input gsgm_reg_e idx, input logic [DATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(8 * idx);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_COEFFS) cfg_coeffs = val;
    else cfg_degree = val[DEG_W-1:0];
  endtask

  // wait until every item is sent and every column is back, then let the block settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_polys.size() != 0 || in_valid_i || expected_columns.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_phase(input logic [DEG_W-1:0] deg, input logic [DATA_W-1:0] coeffs,
                           input int unsigned pct);
    wait_idle();
    reg_write(REG_DEGREE, {{(DATA_W-DEG_W){1'b0}}, deg});
    reg_write(REG_COEFFS, coeffs);
    @(negedge clk_i);
    idle_pct = pct;
  endtask

  // stimulus sequence
  initial begin
    int unsigned      random_sent;
    int unsigned      n, k, pct;
    logic [DEG_W-1:0] deg;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset config: degree 32, plain x^m modulus; high polynomial bits ignored
    @(negedge clk_i);
    add_poly('0);
    add_poly('1);
    add_poly(64'd1);
    add_poly(64'd1 << 31);
    add_poly(64'hFFFF_FFFF_0000_0000);

    // full degree, all-ones modulus
    set_phase(7'd64, '1, 0);
    add_poly('0);
    add_poly('1);
    add_poly(64'd1);
    add_poly(64'd1 << 63);
    add_poly(64'hAAAA_AAAA_AAAA_AAAA);
    add_poly(64'h5555_5555_5555_5555);

    // smallest degree
    set_phase(7'd1, {$urandom, $urandom}, 20);
    add_poly('0);
    add_poly(64'd1);
    add_poly(64'd2);
    add_poly('1);

    // zero degree gives no columns
    set_phase(7'd0, '1, 0);
    for (k = 0; k < 3; k++) add_poly(rand_word());

    // degrees above the maximum saturate
    set_phase(7'd100, 64'h8000_0000_0000_0001, 0);
    for (k = 0; k < 3; k++) add_poly(rand_word());
    set_phase(7'd127, {$urandom, $urandom}, 30);
    add_poly('1);
    add_poly({$urandom, $urandom});

    // long output hold-off at full degree while the sender keeps offering
    set_phase(7'd64, {$urandom, $urandom}, 0);
    for (k = 0; k < 15; k++) add_poly(rand_word());
    hold_req <= 1'b1;
    random_sent = 15;

    // random phases
    while (random_sent < RANDOM_ITEMS - 20) begin
      case ($urandom_range(9))
        0:       deg = 7'd0;
        1:       deg = 7'd64;
        2:       deg = DEG_W'($urandom_range(127, 65));
        3:       deg = DEG_W'($urandom_range(4, 1));
        default: deg = DEG_W'($urandom_range(64, 1));
      endcase
      case ($urandom_range(2))
        0:       pct = 0;
        1:       pct = 15;
        default: pct = 40;
      endcase
      set_phase(deg, rand_word(), pct);
      n = $urandom_range(40, 10);
      for (k = 0; k < n; k++) add_poly(rand_word());
      if (eff_degree(deg) != 0) random_sent += n;
    end

    // closing phase without idling
    set_phase(DEG_W'($urandom_range(64, 1)), {$urandom, $urandom}, 0);
    for (k = 0; k < 20; k++) add_poly(rand_word());

    wait_idle();
    if (mismatch_count == 0 && expected_columns.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gsgm_pkg.sv
rtl/gsgm_cell.sv
rtl/gsgm_ctrl.sv
rtl/gf2_series_generating_matrix_core.sv
tb/sv/tb_gf2_series_generating_matrix_core.sv
